/* rtl/sfs_pkg.sv */
// Shared types, codes and frame functions of the SPI CRC-8 register frame sequencer.
// Used by the request/result interfaces, the frame builder and the top level.
// Depends on nothing.
package sfs_pkg;

    localparam int UNLOCK_LEN = 6;
    localparam int UNLOCK_IDX_W = $clog2(UNLOCK_LEN);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    localparam logic [1:0] WRITE_MARKER_RESET = 2'd2;
    localparam logic [5:0] BANK_SEL_ADDR_RESET = 6'd31;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_WRITE_MARKER  = 1'b0,
        REG_BANK_SEL_ADDR = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_READ      = 2'd1,
        ACT_CHECK     = 2'd2,
        ACT_DEV_RESET = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_UNLOCK,
        PH_BANK,
        PH_ACCESS,
        PH_CLOCKOUT,
        PH_RESPONSE
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  reg_address;
        logic [15:0] bank_code;
        logic        force_bank;
        logic [15:0] write_value;
        logic [31:0] rx_frame;
    } req_t;

    typedef struct packed {
        logic [31:0] tx_frame;
        logic        tx_valid;
        logic [15:0] rx_data;
        logic        crc_ok;
        logic        last;
    } rsp_t;

    // What the frame builder needs to know about the request in progress.
    typedef struct packed {
        logic        is_read;
        logic        need_bank;
        logic [5:0]  reg_address;
        logic [15:0] bank_code;
        logic [15:0] write_value;
        logic [31:0] rx_frame;
    } job_t;

    typedef struct packed {
        logic [1:0] write_marker;
        logic [5:0] bank_sel_addr;
    } cfg_t;

    // CRC-8 over 24 bits, data shifted in at bit 0 as the device computes it.
    // The loop is a linear map, so it reduces to a shallow XOR network.
    function automatic logic [7:0] crc8_24(input logic [23:0] bits);
        logic [7:0] c;
        logic       top;
        c = CRC_INIT;
        for (int i = 23; i >= 0; i--) begin
            top = c[7];
            c = {c[6:0], bits[i]};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        return c ^ CRC_XOROUT;
    endfunction

    function automatic logic [31:0] make_frame(input logic [7:0] addr_byte,
                                               input logic [15:0] value);
        return {addr_byte, value, crc8_24({addr_byte, value})};
    endfunction

    function automatic logic [31:0] unlock_frame(input logic [UNLOCK_IDX_W-1:0] idx);
        logic [31:0] f;
        unique case (idx)
            3'd0:    f = 32'hE400_0288;
            3'd1:    f = 32'hE400_018B;
            3'd2:    f = 32'hE400_048E;
            3'd3:    f = 32'hE403_00AD;
            3'd4:    f = 32'hE401_8017;
            3'd5:    f = 32'hE402_8030;
            default: f = 32'h0000_0000;
        endcase
        return f;
    endfunction

endpackage

/* rtl/sfs_req_if.sv */
// Request channel of the frame sequencer: valid/ready handshake with a req_t payload.
// Depends on sfs_pkg.
interface sfs_req_if import sfs_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/sfs_rsp_if.sv */
// Result channel of the frame sequencer: valid/ready handshake with an rsp_t payload.
// Depends on sfs_pkg.
interface sfs_rsp_if import sfs_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/spi_crc8_register_frame_sequencer_top.sv */
// Top level of the SPI CRC-8 register frame sequencer.
// Depends on sfs_pkg, sfs_req_if, sfs_rsp_if and sfs_frame_builder.
//
// The block turns register access requests into 32-bit SPI frames with a
// trailing CRC-8 (polynomial 0x1D, init and final xor 0xFF).
// Requests arrive on the req channel and results leave on the rsp channel;
// both use a valid/ready handshake. A write request yields an optional
// six-frame unlock run (first access after a device reset), an optional
// bank-select frame and the access frame. A read request adds an all-zero
// clock-out frame. A response check request yields one result with the
// received data and a CRC verdict. A device reset request yields nothing.
// The last result of each request carries last = 1.
// One result leaves per cycle while the receiver takes them, and a request
// yields 1 to 9 results, 2 for a typical read. A device reset request is
// done as soon as it is accepted. The sequence step register and the
// result register set this rate. The accepted request sets the sequence
// step register, from which the first result is loaded into the result
// register, and the next request is taken in the same cycle as the previous
// one's last result moves into the result register, so runs follow back to
// back.
// When the receiver holds ready low the result register keeps its content
// and the sequencer waits; the request side then stalls once its step is
// done. Reset clears the unlock and known-bank state and the configuration
// registers return to write marker 2 and bank select address 31.
// Configuration is written over the APB port at byte addresses 0 and 4.
module spi_crc8_register_frame_sequencer_top import sfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfs_req_if.sink     req,
    sfs_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    cfg_t cfg_reg;

    // Device state as seen by the request stream.
    logic        unlock_done_reg;
    logic        bank_known_reg;
    logic [15:0] current_bank_reg;

    // Sequencer for the request in progress.
    phase_t                  phase_reg;
    phase_t                  phase_next;
    phase_t                  step_phase;
    phase_t                  start_phase;
    logic [UNLOCK_IDX_W-1:0] unlock_idx_reg;
    job_t                    job_reg;
    logic                    step_last;

    // Result register.
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;
    rsp_t step_result;

    logic    out_load;
    logic    advance;
    logic    accept;
    logic    need_bank;
    logic    is_access;
    logic    cfg_write;
    logic    cfg_idx;

    // APB port: always ready, written in the access phase.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_comb
    begin
        unique case (reg_idx_t'(cfg_idx))
            REG_WRITE_MARKER:  prdata = {30'd0, cfg_reg.write_marker};
            REG_BANK_SEL_ADDR: prdata = {26'd0, cfg_reg.bank_sel_addr};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_marker <= WRITE_MARKER_RESET;
            cfg_reg.bank_sel_addr <= BANK_SEL_ADDR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_idx))
                REG_WRITE_MARKER:  cfg_reg.write_marker <= pwdata[1:0];
                REG_BANK_SEL_ADDR: cfg_reg.bank_sel_addr <= pwdata[5:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake. The result register takes a new result whenever it is empty
    // or its content is being taken in this cycle.
    assign out_load = !rsp_valid_reg || rsp.ready;
    assign advance = (phase_reg != PH_IDLE) && out_load;
    assign req.ready = (phase_reg == PH_IDLE) || (advance && step_last);
    assign accept = req.valid && req.ready;

    // Decisions on the incoming request, taken against the state it finds.
    assign is_access = (req.data.action == ACT_WRITE) || (req.data.action == ACT_READ);
    assign need_bank = !bank_known_reg || (req.data.bank_code != current_bank_reg) ||
                       req.data.force_bank;

    always_comb
    begin
        if (req.data.action == ACT_CHECK)
        begin
            start_phase = PH_RESPONSE;
        end
        else if (req.data.action == ACT_DEV_RESET)
        begin
            start_phase = PH_IDLE;
        end
        else if (!unlock_done_reg)
        begin
            start_phase = PH_UNLOCK;
        end
        else if (need_bank)
        begin
            start_phase = PH_BANK;
        end
        else
        begin
            start_phase = PH_ACCESS;
        end
    end

    // Step that follows the current one, and whether the current one ends the run.
    always_comb
    begin
        step_phase = phase_reg;
        step_last = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                step_phase = PH_IDLE;
            end
            PH_UNLOCK:
            begin
                if (unlock_idx_reg == UNLOCK_IDX_W'(UNLOCK_LEN - 1))
                begin
                    step_phase = job_reg.need_bank ? PH_BANK : PH_ACCESS;
                end
            end
            PH_BANK:
            begin
                step_phase = PH_ACCESS;
            end
            PH_ACCESS:
            begin
                if (job_reg.is_read)
                begin
                    step_phase = PH_CLOCKOUT;
                end
                else
                begin
                    step_last = 1'b1;
                end
            end
            PH_CLOCKOUT:
            begin
                step_last = 1'b1;
            end
            PH_RESPONSE:
            begin
                step_last = 1'b1;
            end
            default:
            begin
                step_phase = PH_IDLE;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            phase_next = step_last ? PH_IDLE : step_phase;
        end
        if (accept)
        begin
            phase_next = start_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            unlock_idx_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                unlock_idx_reg <= '0;
            end
            else if (advance && (phase_reg == PH_UNLOCK))
            begin
                unlock_idx_reg <= unlock_idx_reg + 1'b1;
            end
        end
    end

    // Request payload held for the length of its run.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.is_read <= (req.data.action == ACT_READ);
            job_reg.need_bank <= need_bank;
            job_reg.reg_address <= req.data.reg_address;
            job_reg.bank_code <= req.data.bank_code;
            job_reg.write_value <= req.data.write_value;
            job_reg.rx_frame <= req.data.rx_frame;
        end
    end

    // Device state moves on as each request is accepted, so the next request
    // sees it at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_done_reg <= 1'b0;
            bank_known_reg <= 1'b0;
            current_bank_reg <= 16'd0;
        end
        else if (accept)
        begin
            if (req.data.action == ACT_DEV_RESET)
            begin
                unlock_done_reg <= 1'b0;
            end
            else if (is_access)
            begin
                unlock_done_reg <= 1'b1;
                bank_known_reg <= 1'b1;
                current_bank_reg <= req.data.bank_code;
            end
        end
    end

    sfs_frame_builder u_builder (
        .phase      (phase_reg),
        .unlock_idx (unlock_idx_reg),
        .job        (job_reg),
        .cfg        (cfg_reg),
        .last       (step_last),
        .result     (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg <= step_result;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = rsp_data_reg;

endmodule

/* rtl/sfs_frame_builder.sv */
// Result builder: turns the current sequence step of a request into one result.
// Depends on sfs_pkg (frame and CRC functions, types).
module sfs_frame_builder import sfs_pkg::*;
(
    input  phase_t                  phase,
    input  logic [UNLOCK_IDX_W-1:0] unlock_idx,
    input  job_t                    job,
    input  cfg_t                    cfg,
    input  logic                    last,
    output rsp_t                    result
);

    always_comb
    begin
        result = '0;
        result.last = last;
        unique case (phase)
            PH_UNLOCK:
            begin
                result.tx_frame = unlock_frame(unlock_idx);
                result.tx_valid = 1'b1;
            end
            PH_BANK:
            begin
                result.tx_frame = make_frame({cfg.bank_sel_addr, cfg.write_marker},
                                             job.bank_code);
                result.tx_valid = 1'b1;
            end
            PH_ACCESS:
            begin
                if (job.is_read)
                begin
                    result.tx_frame = make_frame({job.reg_address, 2'b00}, 16'h0000);
                end
                else
                begin
                    result.tx_frame = make_frame({job.reg_address, cfg.write_marker},
                                                 job.write_value);
                end
                result.tx_valid = 1'b1;
            end
            PH_CLOCKOUT:
            begin
                // All-zero frame that clocks the read data out of the device.
                result.tx_valid = 1'b1;
            end
            PH_RESPONSE:
            begin
                result.rx_data = job.rx_frame[23:8];
                result.crc_ok = (crc8_24(job.rx_frame[31:8]) == job.rx_frame[7:0]);
            end
            default:
            begin
                result.tx_valid = 1'b0;
            end
        endcase
    end

endmodule
